### rtl/idi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idi_pkg
// Shared types and constants of the inertial double integrator.
// ----------------------------------------------------------------------------
package idi_pkg;

    // item kinds, carried on tuser
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_INTEG   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RST_POS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RST_SPD = 2'd2;

    // integration passes, run in this order for a sample
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_VX  = 3'd0;
    localparam logic [OP_W-1:0] OP_PX  = 3'd1;
    localparam logic [OP_W-1:0] OP_VY  = 3'd2;
    localparam logic [OP_W-1:0] OP_PY  = 3'd3;
    localparam logic [OP_W-1:0] OP_VZ  = 3'd4;
    localparam logic [OP_W-1:0] OP_PZ  = 3'd5;
    localparam logic [OP_W-1:0] OP_ANG = 3'd6;

    // accumulator widths
    localparam int POS_W = 64;
    localparam int VEL_W = 48;

    // multiplier slice and divide-by-1000 digit unit
    localparam int MUL_W   = 32;
    localparam int HI_W    = VEL_W - MUL_W;
    localparam int DIG_W   = 4;
    localparam int REM_W   = 10;
    localparam int TMP_W   = REM_W + DIG_W;
    localparam int DIVISOR = 1000;

    // controller to datapath
    typedef struct packed {
        logic            load_item;
        logic            clr_pos;
        logic            clr_speed;
        logic            load_opnd;
        logic            mul_lo;
        logic            mul_hi;
        logic            div_step;
        logic            acc_write;
        logic            out_load;
        logic [OP_W-1:0] op;
    } idi_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] kind;
    } idi_stat_t;

    function automatic logic [TMP_W-1:0] times_divisor(input logic [DIG_W-1:0] d);
        return TMP_W'(d) * TMP_W'(DIVISOR);
    endfunction

endpackage

### rtl/inertial_double_integrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inertial_double_integrator_unit
// Dead-reckoning double integrator for IMU samples (8 fraction bits).
// ----------------------------------------------------------------------------
// Each item on the slave stream is either an IMU sample (kind 0) or a reset
// command (kind 1 clears position and angle, kind 2 clears speed and rate and
// takes the item's accelerations as the gravity baseline); any other kind
// leaves the state alone. Every item yields exactly one result item: the
// positions, angle, speeds and last rate after that item. A sample runs seven
// passes (speed then position for x, y, z, then angle) through one shared
// datapath: operand load, a 32-bit and a 16-bit multiplier slice, NDIG
// radix-16 steps dividing by 1000 and one saturating accumulate, with
// NDIG = ceil((48 + DT_BITS) / 4). A finished result waits in an output
// register, so the next item is taken while it is still unread; only the
// hand-off of the following result waits for it.
// ----------------------------------------------------------------------------
module inertial_double_integrator_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int DT_BITS     = 20
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tuser: cmd[1:0]
    input  logic [1:0]                            s_tuser,
    // tdata: accel_x, accel_y, accel_z, yaw_rate (SAMPLE_BITS each),
    //        dt_x, dt_y, dt_z, dt_rot (DT_BITS each), zero pad to bytes
    input  logic [((4*SAMPLE_BITS+4*DT_BITS+7)/8)*8-1:0] s_tdata,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // tdata: pos_x, pos_y, pos_z, angle (64 each), vel_x, vel_y, vel_z
    //        (48 each), rot_rate (SAMPLE_BITS), zero pad to bytes
    output logic [((400+SAMPLE_BITS+7)/8)*8-1:0]  m_tdata
);
    import idi_pkg::*;

    localparam int IN_W  = ((4*SAMPLE_BITS + 4*DT_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((4*POS_W + 3*VEL_W + SAMPLE_BITS + 7) / 8) * 8;

    idi_ctl_t  ctl;   // sequencer commands
    idi_stat_t stat;  // item kind back to the sequencer

    idi_ctrl #(
        .DT_BITS (DT_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    idi_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DT_BITS     (DT_BITS),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .stat    (stat),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

### rtl/idi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idi_ctrl
// Sequencer: decodes the item kind, steps the seven integration passes
// through operand, multiply, digit divide and accumulate, hands off results.
// ----------------------------------------------------------------------------
module idi_ctrl #(
    parameter int DT_BITS = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  idi_pkg::idi_stat_t  stat,
    output idi_pkg::idi_ctl_t   ctl
);
    import idi_pkg::*;

    localparam int NDIG  = (VEL_W + DT_BITS + DIG_W - 1) / DIG_W;
    localparam int CNT_W = $clog2(NDIG);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_OPND   = 3'd2;
    localparam logic [2:0] ST_MUL_LO = 3'd3;
    localparam logic [2:0] ST_MUL_HI = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_ADD    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             oval_reg, oval_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_VX;
            cnt_reg   <= '0;
            oval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            oval_reg  <= oval_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        ctl.op     = op_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.kind)
                    CMD_INTEG: begin
                        op_next    = OP_VX;
                        state_next = ST_OPND;
                    end
                    CMD_RST_POS: begin
                        ctl.clr_pos = 1'b1;
                        state_next  = ST_DONE;
                    end
                    CMD_RST_SPD: begin
                        ctl.clr_speed = 1'b1;
                        state_next    = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_OPND: begin
                ctl.load_opnd = 1'b1;
                state_next    = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                ctl.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                ctl.mul_hi = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                ctl.div_step = 1'b1;
                if (cnt_reg == CNT_W'(NDIG - 1)) begin
                    state_next = ST_ADD;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ADD: begin
                ctl.acc_write = 1'b1;
                if (op_reg == OP_ANG) begin
                    state_next = ST_DONE;
                end else begin
                    // passes are numbered in running order
                    op_next    = op_reg + OP_W'(1);
                    state_next = ST_OPND;
                end
            end
            ST_DONE: begin
                if (!oval_reg || m_tready) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        oval_next = oval_reg;
        if (ctl.out_load) begin
            oval_next = 1'b1;
        end else if (m_tready) begin
            oval_next = 1'b0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = oval_reg;

endmodule

### rtl/idi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idi_datapath
// Item and state registers, 32-bit and 16-bit multiplier slices, radix-16
// divide-by-1000 digit unit, saturating accumulate and output register.
// ----------------------------------------------------------------------------
module idi_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int DT_BITS     = 20,
    parameter int IN_W        = 144,
    parameter int OUT_W       = 416
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  idi_pkg::idi_ctl_t   ctl,
    output idi_pkg::idi_stat_t  stat,
    input  logic [1:0]          s_tuser,
    input  logic [IN_W-1:0]     s_tdata,
    output logic [OUT_W-1:0]    m_tdata
);
    import idi_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int DB   = DT_BITS;
    localparam int NDIG = (VEL_W + DB + DIG_W - 1) / DIG_W;
    localparam int PP   = NDIG * DIG_W;
    localparam int SW   = ((PP > POS_W) ? PP : POS_W) + 2;
    localparam int OFF_DT = 4 * SB;

    // item
    logic [CMD_W-1:0]     kind_reg;
    logic signed [SB-1:0] ax_reg, ay_reg, az_reg, yaw_reg;
    logic [DB-1:0]        dtx_reg, dty_reg, dtz_reg, dtr_reg;

    // state
    logic signed [SB-1:0]    gx_reg, gy_reg, gz_reg, rate_reg;
    logic signed [VEL_W-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg, ang_reg;

    // operand, product / quotient, remainder
    logic [VEL_W-1:0] mag_reg;
    logic             neg_reg;
    logic [DB-1:0]    dt_reg;
    logic [PP-1:0]    prod_reg;
    logic [REM_W-1:0] rem_reg;
    logic [OUT_W-1:0] out_reg;

    logic signed [VEL_W-1:0] val_sel;
    logic [DB-1:0]           dt_sel;
    logic signed [SB:0]      diff;
    logic signed [SB-1:0]    acc_s, grav_s;
    logic [VEL_W-1:0]        mag;
    logic [MUL_W+DB-1:0]     p_lo;
    logic [HI_W+DB-1:0]      p_hi;
    logic [TMP_W-1:0]        part;
    logic [DIG_W-1:0]        qd;
    logic [TMP_W-1:0]        rem_full;
    logic                    is_speed;
    logic signed [SW-1:0]    acc_ext, q_ext, sum, hi_b, lo_b, res;

    // operand selection for the current pass
    always_comb begin
        acc_s    = ax_reg;
        grav_s   = gx_reg;
        val_sel  = '0;
        dt_sel   = dtx_reg;
        is_speed = 1'b0;
        acc_ext  = '0;
        unique case (ctl.op)
            OP_VX: begin
                acc_s = ax_reg; grav_s = gx_reg; dt_sel = dtx_reg; is_speed = 1'b1;
                acc_ext = SW'(vx_reg);
            end
            OP_PX: begin
                val_sel = vx_reg; dt_sel = dtx_reg; acc_ext = SW'(px_reg);
            end
            OP_VY: begin
                acc_s = ay_reg; grav_s = gy_reg; dt_sel = dty_reg; is_speed = 1'b1;
                acc_ext = SW'(vy_reg);
            end
            OP_PY: begin
                val_sel = vy_reg; dt_sel = dty_reg; acc_ext = SW'(py_reg);
            end
            OP_VZ: begin
                acc_s = az_reg; grav_s = gz_reg; dt_sel = dtz_reg; is_speed = 1'b1;
                acc_ext = SW'(vz_reg);
            end
            OP_PZ: begin
                val_sel = vz_reg; dt_sel = dtz_reg; acc_ext = SW'(pz_reg);
            end
            OP_ANG: begin
                val_sel = VEL_W'(yaw_reg); dt_sel = dtr_reg; acc_ext = SW'(ang_reg);
            end
            default: begin
                val_sel = '0;
            end
        endcase
        diff = (SB+1)'(acc_s) - (SB+1)'(grav_s);
        if (is_speed) begin
            val_sel = VEL_W'(diff);
        end
    end

    assign mag = val_sel[VEL_W-1] ? (VEL_W'(0) - val_sel) : val_sel;

    // product slices
    assign p_lo = (MUL_W+DB)'(mag_reg[MUL_W-1:0]) * (MUL_W+DB)'(dt_reg);
    assign p_hi = (HI_W+DB)'(mag_reg[VEL_W-1:MUL_W]) * (HI_W+DB)'(dt_reg);

    // one quotient digit per step
    assign part = {rem_reg, prod_reg[PP-1 -: DIG_W]};
    always_comb begin
        qd = '0;
        for (int k = 1; k < (1 << DIG_W); k++) begin
            if (part >= times_divisor(DIG_W'(k))) begin
                qd = DIG_W'(k);
            end
        end
    end
    assign rem_full = part - times_divisor(qd);

    // saturating accumulate; min bound is the complement of max
    assign q_ext = SW'(prod_reg);
    assign sum   = neg_reg ? (acc_ext - q_ext) : (acc_ext + q_ext);
    assign hi_b  = is_speed ? SW'({1'b0, {(VEL_W-1){1'b1}}})
                            : SW'({1'b0, {(POS_W-1){1'b1}}});
    assign lo_b  = ~hi_b;
    assign res   = (sum > hi_b) ? hi_b : ((sum < lo_b) ? lo_b : sum);

    // item and operand registers
    always_ff @(posedge aclk) begin
        if (ctl.load_item) begin
            kind_reg <= s_tuser;
            ax_reg   <= s_tdata[0*SB +: SB];
            ay_reg   <= s_tdata[1*SB +: SB];
            az_reg   <= s_tdata[2*SB +: SB];
            yaw_reg  <= s_tdata[3*SB +: SB];
            dtx_reg  <= s_tdata[OFF_DT + 0*DB +: DB];
            dty_reg  <= s_tdata[OFF_DT + 1*DB +: DB];
            dtz_reg  <= s_tdata[OFF_DT + 2*DB +: DB];
            dtr_reg  <= s_tdata[OFF_DT + 3*DB +: DB];
        end
        if (ctl.load_opnd) begin
            mag_reg <= mag;
            neg_reg <= val_sel[VEL_W-1];
            dt_reg  <= dt_sel;
            rem_reg <= '0;
        end
        if (ctl.mul_lo) begin
            prod_reg <= PP'(p_lo);
        end else if (ctl.mul_hi) begin
            prod_reg <= prod_reg + (PP'(p_hi) << MUL_W);
        end else if (ctl.div_step) begin
            prod_reg <= {prod_reg[PP-DIG_W-1:0], qd};
            rem_reg  <= rem_full[REM_W-1:0];
        end
        if (ctl.out_load) begin
            out_reg <= OUT_W'({rate_reg, vz_reg, vy_reg, vx_reg,
                               ang_reg, pz_reg, py_reg, px_reg});
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_reg   <= '0;
            gy_reg   <= '0;
            gz_reg   <= '0;
            rate_reg <= '0;
            vx_reg   <= '0;
            vy_reg   <= '0;
            vz_reg   <= '0;
            px_reg   <= '0;
            py_reg   <= '0;
            pz_reg   <= '0;
            ang_reg  <= '0;
        end else if (ctl.clr_pos) begin
            px_reg  <= '0;
            py_reg  <= '0;
            pz_reg  <= '0;
            ang_reg <= '0;
        end else if (ctl.clr_speed) begin
            vx_reg   <= '0;
            vy_reg   <= '0;
            vz_reg   <= '0;
            rate_reg <= '0;
            gx_reg   <= ax_reg;
            gy_reg   <= ay_reg;
            gz_reg   <= az_reg;
        end else if (ctl.acc_write) begin
            unique case (ctl.op)
                OP_VX:   vx_reg <= res[VEL_W-1:0];
                OP_PX:   px_reg <= res[POS_W-1:0];
                OP_VY:   vy_reg <= res[VEL_W-1:0];
                OP_PY:   py_reg <= res[POS_W-1:0];
                OP_VZ:   vz_reg <= res[VEL_W-1:0];
                OP_PZ:   pz_reg <= res[POS_W-1:0];
                OP_ANG: begin
                    ang_reg  <= res[POS_W-1:0];
                    rate_reg <= yaw_reg;
                end
                default: begin
                end
            endcase
        end
    end

    assign stat.kind = kind_reg;
    assign m_tdata   = out_reg;

endmodule
